FILE: hdl/rcpm_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rcpm_pkg
// Shared constants, codes and types for the reference counted pointer map.
// ----------------------------------------------------------------------------
package rcpm_pkg;

    localparam int ENTRIES  = 64;
    localparam int REF_BITS = 16;
    localparam int IDX_W    = $clog2(ENTRIES);

    localparam int MODE_W   = 3;
    localparam int KEY_W    = 64;
    localparam int HALF_W   = 16;
    localparam int FAR_W    = 2 * HALF_W;
    localparam int PCNT_W   = 7;
    localparam int STATUS_W = 2;

    localparam logic [MODE_W-1:0] MODE_STORE   = 3'd0;
    localparam logic [MODE_W-1:0] MODE_REPLACE = 3'd1;
    localparam logic [MODE_W-1:0] MODE_LOOKUP  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_REF     = 3'd3;
    localparam logic [MODE_W-1:0] MODE_UNREF   = 3'd4;
    localparam logic [MODE_W-1:0] MODE_PURGE   = 3'd5;

    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_MISS     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_MISMATCH = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL     = 2'd3;

    localparam logic [REF_BITS-1:0] REF_MAX = '1;
    localparam logic [REF_BITS-1:0] REF_ONE = REF_BITS'(1);

    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(ENTRIES - 1);

    typedef logic [IDX_W-1:0] idx_t;

    // commands from the controller to the datapath
    typedef struct packed {
        logic load;    // capture the input word, restart the sweep
        logic step;    // one entry of the sweep (search read or purge)
        logic update;  // write back and register the result
    } rcpm_cmd_t;

endpackage : rcpm_pkg
`default_nettype wire

FILE: hdl/rcpm_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rcpm_ctrl
// Sequencer: accept a command, sweep every entry, drain the compare stage,
// then issue one update cycle.
// ----------------------------------------------------------------------------
module rcpm_ctrl
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    input  wire logic                last,
    output rcpm_pkg::rcpm_cmd_t      cmd,
    output logic                     busy
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_STEP   = 2'd1;
    localparam logic [1:0] S_DRAIN  = 2'd2;
    localparam logic [1:0] S_UPDATE = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        cmd         = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_STEP;
                end
            end
            S_STEP:
            begin
                cmd.step = 1'b1;
                if (last)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                state_next = S_UPDATE;
            end
            S_UPDATE:
            begin
                cmd.update = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != S_IDLE);

endmodule : rcpm_ctrl
`default_nettype wire

FILE: hdl/rcpm_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rcpm_dp
// Table storage, sweep counter, key compare stage, write-back and result
// registers.
// ----------------------------------------------------------------------------
module rcpm_dp
(
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire rcpm_pkg::rcpm_cmd_t                    cmd,
    input  wire logic [rcpm_pkg::MODE_W-1:0]            mode,
    input  wire logic [rcpm_pkg::KEY_W-1:0]             key,
    input  wire logic [rcpm_pkg::HALF_W-1:0]            seg_in,
    input  wire logic [rcpm_pkg::HALF_W-1:0]            off_in,
    output logic                                        last,
    output logic                                        done,
    output logic [rcpm_pkg::HALF_W-1:0]                 seg_out,
    output logic [rcpm_pkg::HALF_W-1:0]                 off_out,
    output logic                                        removed,
    output logic [rcpm_pkg::PCNT_W-1:0]                 purged_count,
    output logic [rcpm_pkg::STATUS_W-1:0]               status
);

    // captured command word
    logic [rcpm_pkg::MODE_W-1:0]   mode_reg;
    logic [rcpm_pkg::KEY_W-1:0]    key_reg;
    logic [rcpm_pkg::FAR_W-1:0]    pair_reg;

    // sweep
    rcpm_pkg::idx_t                cnt_reg;
    logic [rcpm_pkg::PCNT_W-1:0]   pcnt_reg;
    logic                          search_op;
    logic                          purge_op;

    // table
    logic [rcpm_pkg::ENTRIES-1:0]  valid_reg;
    logic [rcpm_pkg::KEY_W-1:0]    key_mem  [rcpm_pkg::ENTRIES];
    logic [rcpm_pkg::FAR_W-1:0]    far_mem  [rcpm_pkg::ENTRIES];
    logic [rcpm_pkg::REF_BITS-1:0] refs_mem [rcpm_pkg::ENTRIES];

    // compare stage
    logic                          cmp_en_reg;
    rcpm_pkg::idx_t                cmp_idx_reg;
    logic [rcpm_pkg::KEY_W-1:0]    key_rd_reg;
    logic [rcpm_pkg::FAR_W-1:0]    far_rd_reg;
    logic [rcpm_pkg::REF_BITS-1:0] refs_rd_reg;
    logic                          hit_now;
    logic                          free_now;

    logic                          hit_reg;
    rcpm_pkg::idx_t                hit_idx_reg;
    logic [rcpm_pkg::FAR_W-1:0]    hit_far_reg;
    logic [rcpm_pkg::REF_BITS-1:0] hit_refs_reg;
    logic                          free_reg;
    rcpm_pkg::idx_t                free_idx_reg;

    // write back
    rcpm_pkg::idx_t                wr_idx;
    logic                          key_we;
    logic                          far_we;
    logic                          refs_we;
    logic [rcpm_pkg::REF_BITS-1:0] refs_wr;
    logic                          set_valid;
    logic                          clr_valid;
    logic [rcpm_pkg::FAR_W-1:0]    far_res;
    logic                          removed_res;
    logic [rcpm_pkg::STATUS_W-1:0] status_res;

    // result registers
    logic                          done_reg;
    logic [rcpm_pkg::HALF_W-1:0]   seg_out_reg;
    logic [rcpm_pkg::HALF_W-1:0]   off_out_reg;
    logic                          removed_reg;
    logic [rcpm_pkg::PCNT_W-1:0]   purged_reg;
    logic [rcpm_pkg::STATUS_W-1:0] status_reg;

    always_comb
    begin
        search_op = mode_reg inside {rcpm_pkg::MODE_STORE, rcpm_pkg::MODE_REPLACE,
                                     rcpm_pkg::MODE_LOOKUP, rcpm_pkg::MODE_REF,
                                     rcpm_pkg::MODE_UNREF};
        purge_op  = (mode_reg == rcpm_pkg::MODE_PURGE);
    end

    assign last = (cnt_reg == rcpm_pkg::IDX_LAST);

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mode_reg <= mode;
            key_reg  <= key;
            pair_reg <= {seg_in, off_in};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            pcnt_reg <= '0;
        end
        else if (cmd.load)
        begin
            cnt_reg  <= '0;
            pcnt_reg <= '0;
        end
        else if (cmd.step)
        begin
            cnt_reg <= cnt_reg + rcpm_pkg::IDX_W'(1);
            if (purge_op)
            begin
                // the count is PCNT_W bits wide, enough for all ENTRIES slots without wrapping
                pcnt_reg <= pcnt_reg + rcpm_pkg::PCNT_W'(valid_reg[cnt_reg]);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (cmd.step && purge_op)
            begin
                valid_reg[cnt_reg] <= 1'b0;
            end
            if (set_valid)
            begin
                valid_reg[wr_idx] <= 1'b1;
            end
            if (clr_valid)
            begin
                valid_reg[wr_idx] <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (key_we)
        begin
            key_mem[wr_idx] <= key_reg;
        end
        if (far_we)
        begin
            far_mem[wr_idx] <= pair_reg;
        end
        if (refs_we)
        begin
            refs_mem[wr_idx] <= refs_wr;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.step)
        begin
            key_rd_reg  <= key_mem[cnt_reg];
            far_rd_reg  <= far_mem[cnt_reg];
            refs_rd_reg <= refs_mem[cnt_reg];
            cmp_idx_reg <= cnt_reg;
        end
    end

    assign hit_now  = cmp_en_reg && valid_reg[cmp_idx_reg] && (key_rd_reg == key_reg);
    assign free_now = cmp_en_reg && !valid_reg[cmp_idx_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmp_en_reg <= 1'b0;
            hit_reg    <= 1'b0;
            free_reg   <= 1'b0;
        end
        else
        begin
            cmp_en_reg <= cmd.step && search_op;
            if (cmd.load)
            begin
                hit_reg  <= 1'b0;
                free_reg <= 1'b0;
            end
            else
            begin
                if (hit_now)
                begin
                    hit_reg <= 1'b1;
                end
                // keep the lowest free slot
                if (free_now && !free_reg)
                begin
                    free_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (hit_now)
        begin
            hit_idx_reg  <= cmp_idx_reg;
            hit_far_reg  <= far_rd_reg;
            hit_refs_reg <= refs_rd_reg;
        end
        if (free_now && !free_reg)
        begin
            free_idx_reg <= cmp_idx_reg;
        end
    end

    always_comb
    begin
        wr_idx      = hit_idx_reg;
        key_we      = 1'b0;
        far_we      = 1'b0;
        refs_we     = 1'b0;
        refs_wr     = rcpm_pkg::REF_ONE;
        set_valid   = 1'b0;
        clr_valid   = 1'b0;
        far_res     = '0;
        removed_res = 1'b0;
        status_res  = rcpm_pkg::ST_OK;
        if (cmd.update)
        begin
            case (mode_reg)
                rcpm_pkg::MODE_STORE, rcpm_pkg::MODE_REPLACE:
                begin
                    if (hit_reg)
                    begin
                        if (mode_reg == rcpm_pkg::MODE_REPLACE)
                        begin
                            far_we  = 1'b1;
                            refs_we = 1'b1;
                            far_res = pair_reg;
                        end
                        else
                        begin
                            far_res = hit_far_reg;
                            if (hit_far_reg != pair_reg)
                            begin
                                status_res = rcpm_pkg::ST_MISMATCH;
                            end
                        end
                    end
                    else if (free_reg)
                    begin
                        wr_idx    = free_idx_reg;
                        key_we    = 1'b1;
                        far_we    = 1'b1;
                        refs_we   = 1'b1;
                        set_valid = 1'b1;
                        far_res   = pair_reg;
                    end
                    else
                    begin
                        status_res = rcpm_pkg::ST_FULL;
                    end
                end
                rcpm_pkg::MODE_LOOKUP, rcpm_pkg::MODE_REF, rcpm_pkg::MODE_UNREF:
                begin
                    if (!hit_reg)
                    begin
                        status_res = rcpm_pkg::ST_MISS;
                    end
                    else
                    begin
                        far_res = hit_far_reg;
                        if (mode_reg == rcpm_pkg::MODE_REF)
                        begin
                            // saturate at the top of the count
                            refs_we = (hit_refs_reg != rcpm_pkg::REF_MAX);
                            refs_wr = hit_refs_reg + rcpm_pkg::REF_ONE;
                        end
                        else if (mode_reg == rcpm_pkg::MODE_UNREF)
                        begin
                            if (hit_refs_reg <= rcpm_pkg::REF_ONE)
                            begin
                                clr_valid   = 1'b1;
                                removed_res = 1'b1;
                            end
                            else
                            begin
                                refs_we = 1'b1;
                                refs_wr = hit_refs_reg - rcpm_pkg::REF_ONE;
                            end
                        end
                    end
                end
                default:
                begin
                    far_res = '0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.update;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.update)
        begin
            seg_out_reg <= far_res[rcpm_pkg::FAR_W-1:rcpm_pkg::HALF_W];
            off_out_reg <= far_res[rcpm_pkg::HALF_W-1:0];
            removed_reg <= removed_res;
            purged_reg  <= purge_op ? pcnt_reg : '0;
            status_reg  <= status_res;
        end
    end

    assign done         = done_reg;
    assign seg_out      = seg_out_reg;
    assign off_out      = off_out_reg;
    assign removed      = removed_reg;
    assign purged_count = purged_reg;
    assign status       = status_reg;

endmodule : rcpm_dp
`default_nettype wire

FILE: hdl/refcounted_pointer_map.sv
`default_nettype none
// ----------------------------------------------------------------------------
// refcounted_pointer_map
// Fixed-size table mapping a 64-bit key to a segment:offset pair with a
// reference count: store, replace, lookup, lookup_ref, lookup_unref, purge.
//
//   channel  | handshake       | word
//   ---------+-----------------+------------------------------------------
//   command  | start / busy    | mode, key, seg_in, off_in
//   result   | done (1 cycle)  | seg_out, off_out, removed, purged_count,
//            |                 | status
//
// Every command sweeps all ENTRIES slots, one per cycle through the single
// read port of the table memory, then drains the compare stage and does one
// write-back; done is registered from that write-back. busy drops in the
// cycle done shows, so a new command may be accepted then. The receiver
// cannot stall; done is a one cycle strobe. Reset clears all valid bits at
// once; no sweep is needed.
// ----------------------------------------------------------------------------
module refcounted_pointer_map
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic [rcpm_pkg::MODE_W-1:0]   mode,
    input  wire logic [rcpm_pkg::KEY_W-1:0]    key,
    input  wire logic [rcpm_pkg::HALF_W-1:0]   seg_in,
    input  wire logic [rcpm_pkg::HALF_W-1:0]   off_in,
    output logic                               done,
    output logic [rcpm_pkg::HALF_W-1:0]        seg_out,
    output logic [rcpm_pkg::HALF_W-1:0]        off_out,
    output logic                               removed,
    output logic [rcpm_pkg::PCNT_W-1:0]        purged_count,
    output logic [rcpm_pkg::STATUS_W-1:0]      status
);

    rcpm_pkg::rcpm_cmd_t cmd;
    logic                last;

    rcpm_ctrl u_ctrl
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .last  (last),
        .cmd   (cmd),
        .busy  (busy)
    );

    rcpm_dp u_dp
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .mode         (mode),
        .key          (key),
        .seg_in       (seg_in),
        .off_in       (off_in),
        .last         (last),
        .done         (done),
        .seg_out      (seg_out),
        .off_out      (off_out),
        .removed      (removed),
        .purged_count (purged_count),
        .status       (status)
    );

endmodule : refcounted_pointer_map
`default_nettype wire

FILE: hdl/rcpm_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rcpm_checker
// Port-level checks on the command and result channels of the pointer map.
// ----------------------------------------------------------------------------
module rcpm_checker
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire logic                          busy,
    input  wire logic                          done,
    input  wire logic [rcpm_pkg::HALF_W-1:0]   seg_out,
    input  wire logic [rcpm_pkg::HALF_W-1:0]   off_out,
    input  wire logic                          removed,
    input  wire logic [rcpm_pkg::PCNT_W-1:0]   purged_count,
    input  wire logic [rcpm_pkg::STATUS_W-1:0] status
);

    // an accepted word keeps the block busy in the next cycle
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("busy not raised after accepted command");

    // the result shows exactly when the block goes idle
    a_done_on_fall: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> done)
        else $error("busy dropped without a result");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while busy");

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && (status == rcpm_pkg::ST_MISS || status == rcpm_pkg::ST_FULL)
        |-> seg_out == '0 && off_out == '0 && !removed && purged_count == '0)
        else $error("miss or full result carries data");

    a_removed_ok: assert property (@(posedge clk) disable iff (!rst_n)
        done && removed |-> status == rcpm_pkg::ST_OK && purged_count == '0)
        else $error("removal reported with bad status");

endmodule : rcpm_checker

bind refcounted_pointer_map rcpm_checker u_rcpm_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .done         (done),
    .seg_out      (seg_out),
    .off_out      (off_out),
    .removed      (removed),
    .purged_count (purged_count),
    .status       (status)
);
`default_nettype wire

FILE: sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for refcounted_pointer_map. A shadow copy of the table
// predicts every reply. Directed tasks cover each mode, store conflicts,
// removal by unref, spare modes and a full table; then random traffic follows
// over a small pool of keys, with random gaps in front of commands.
// ----------------------------------------------------------------------------
module tb;

    localparam logic [rcpm_pkg::MODE_W-1:0] MODE_SPARE_6 = 3'd6;
    localparam logic [rcpm_pkg::MODE_W-1:0] MODE_SPARE_7 = 3'd7;
    localparam int POOL_KEYS = 16;
    localparam int RANDOM_WORDS = 350;

    typedef struct packed {
        logic [rcpm_pkg::HALF_W-1:0]   seg;
        logic [rcpm_pkg::HALF_W-1:0]   off;
        logic                          removed;
        logic [rcpm_pkg::PCNT_W-1:0]   purged;
        logic [rcpm_pkg::STATUS_W-1:0] status;
    } reply_t;

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          start = 1'b0;
    logic [rcpm_pkg::MODE_W-1:0]   mode = '0;
    logic [rcpm_pkg::KEY_W-1:0]    key = '0;
    logic [rcpm_pkg::HALF_W-1:0]   seg_in = '0;
    logic [rcpm_pkg::HALF_W-1:0]   off_in = '0;
    logic                          busy;
    logic                          done;
    logic [rcpm_pkg::HALF_W-1:0]   seg_out;
    logic [rcpm_pkg::HALF_W-1:0]   off_out;
    logic                          removed;
    logic [rcpm_pkg::PCNT_W-1:0]   purged_count;
    logic [rcpm_pkg::STATUS_W-1:0] status;

    // shadow table
    logic                          tab_valid [rcpm_pkg::ENTRIES];
    logic [rcpm_pkg::KEY_W-1:0]    tab_key   [rcpm_pkg::ENTRIES];
    logic [rcpm_pkg::FAR_W-1:0]    tab_far   [rcpm_pkg::ENTRIES];
    logic [rcpm_pkg::REF_BITS-1:0] tab_refs  [rcpm_pkg::ENTRIES];

    reply_t pending_replies [$];
    logic [rcpm_pkg::KEY_W-1:0]  key_pool  [POOL_KEYS];
    logic [rcpm_pkg::FAR_W-1:0]  pair_pool [POOL_KEYS];

    int  errors = 0;
    int  n_words = 0;
    int  n_hits = 0;
    int  n_misses = 0;
    int  n_conflicts = 0;
    int  n_full = 0;
    int  n_erased = 0;
    int  n_purges = 0;
    bit  gaps_on = 1'b1;

    refcounted_pointer_map dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .mode         (mode),
        .key          (key),
        .seg_in       (seg_in),
        .off_in       (off_in),
        .done         (done),
        .seg_out      (seg_out),
        .off_out      (off_out),
        .removed      (removed),
        .purged_count (purged_count),
        .status       (status)
    );

    always #2 clk = ~clk;

    initial
    begin
        #2_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Apply one command to the shadow table and return its reply.
    function automatic reply_t map_command(input logic [rcpm_pkg::MODE_W-1:0] m,
                                           input logic [rcpm_pkg::KEY_W-1:0] k,
                                           input logic [rcpm_pkg::HALF_W-1:0] s,
                                           input logic [rcpm_pkg::HALF_W-1:0] o);
        reply_t                     r;
        logic [rcpm_pkg::FAR_W-1:0] pair;
        int                         hit;
        int                         slot;
        int                         count;
        r = '0;
        pair = {s, o};
        hit = -1;
        slot = -1;
        count = 0;
        for (int i = 0; i < rcpm_pkg::ENTRIES; i++)
        begin
            if (hit < 0 && tab_valid[i] && tab_key[i] == k)
                hit = i;
            if (slot < 0 && !tab_valid[i])
                slot = i;
        end
        case (m)
            rcpm_pkg::MODE_STORE, rcpm_pkg::MODE_REPLACE:
            begin
                if (hit >= 0)
                begin
                    if (m == rcpm_pkg::MODE_REPLACE)
                    begin
                        tab_far[hit] = pair;
                        tab_refs[hit] = rcpm_pkg::REF_ONE;
                    end
                    else if (tab_far[hit] != pair)
                        r.status = rcpm_pkg::ST_MISMATCH;
                    {r.seg, r.off} = tab_far[hit];
                end
                else if (slot < 0)
                    r.status = rcpm_pkg::ST_FULL;
                else
                begin
                    tab_valid[slot] = 1'b1;
                    tab_key[slot] = k;
                    tab_far[slot] = pair;
                    tab_refs[slot] = rcpm_pkg::REF_ONE;
                    {r.seg, r.off} = pair;
                end
            end
            rcpm_pkg::MODE_LOOKUP, rcpm_pkg::MODE_REF, rcpm_pkg::MODE_UNREF:
            begin
                if (hit < 0)
                    r.status = rcpm_pkg::ST_MISS;
                else
                begin
                    {r.seg, r.off} = tab_far[hit];
                    if (m == rcpm_pkg::MODE_REF)
                    begin
                        // hold at the ceiling
                        if (tab_refs[hit] != rcpm_pkg::REF_MAX)
                            tab_refs[hit] = tab_refs[hit] + rcpm_pkg::REF_ONE;
                    end
                    else if (m == rcpm_pkg::MODE_UNREF)
                    begin
                        if (tab_refs[hit] <= rcpm_pkg::REF_ONE)
                        begin
                            tab_refs[hit] = '0;
                            tab_valid[hit] = 1'b0;
                            r.removed = 1'b1;
                        end
                        else
                            tab_refs[hit] = tab_refs[hit] - rcpm_pkg::REF_ONE;
                    end
                end
            end
            rcpm_pkg::MODE_PURGE:
            begin
                for (int i = 0; i < rcpm_pkg::ENTRIES; i++)
                begin
                    if (tab_valid[i])
                        count++;
                    tab_valid[i] = 1'b0;
                end
                r.purged = rcpm_pkg::PCNT_W'(count);
            end
            default: ;
        endcase
        return r;
    endfunction

    // Present one word and hold it until the block takes it; return at a
    // falling edge with start still high.
    task automatic issue(input logic [rcpm_pkg::MODE_W-1:0] m,
                         input logic [rcpm_pkg::KEY_W-1:0] k,
                         input logic [rcpm_pkg::HALF_W-1:0] s,
                         input logic [rcpm_pkg::HALF_W-1:0] o);
        mode = m;
        key = k;
        seg_in = s;
        off_in = o;
        start = 1'b1;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        pending_replies.push_back(map_command(m, k, s, o));
        n_words++;
        @(negedge clk);
    endtask

    // Random gap, if any, before the next word, either inside the busy window or
    // after the block frees up.
    task automatic sender_gap();
        int n;
        n = $urandom_range(1, 15);
        if (!gaps_on || $urandom_range(0, 2) == 0)
            return;
        start = 1'b0;
        if ($urandom_range(0, 1) == 1)
        begin
            do
                @(posedge clk);
            while (busy);
            @(negedge clk);
        end
        repeat (n) @(negedge clk);
    endtask

    task automatic send(input logic [rcpm_pkg::MODE_W-1:0] m,
                        input logic [rcpm_pkg::KEY_W-1:0] k,
                        input logic [rcpm_pkg::HALF_W-1:0] s,
                        input logic [rcpm_pkg::HALF_W-1:0] o);
        sender_gap();
        issue(m, k, s, o);
    endtask

    always @(posedge clk)
    begin : check_replies
        reply_t want;
        if (rst_n && done)
        begin
            if (pending_replies.size() == 0)
            begin
                $error("reply with no command outstanding");
                errors++;
            end
            else
            begin
                want = pending_replies.pop_front();
                if (seg_out !== want.seg)
                begin
                    $error("seg_out: expected %h, got %h", want.seg, seg_out);
                    errors++;
                end
                if (off_out !== want.off)
                begin
                    $error("off_out: expected %h, got %h", want.off, off_out);
                    errors++;
                end
                if (removed !== want.removed)
                begin
                    $error("removed: expected %b, got %b", want.removed, removed);
                    errors++;
                end
                if (purged_count !== want.purged)
                begin
                    $error("purged_count: expected %0d, got %0d", want.purged,
                           purged_count);
                    errors++;
                end
                if (status !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, status);
                    errors++;
                end
                case (want.status)
                    rcpm_pkg::ST_MISS:     n_misses++;
                    rcpm_pkg::ST_MISMATCH: n_conflicts++;
                    rcpm_pkg::ST_FULL:     n_full++;
                    default:               n_hits++;
                endcase
                if (want.removed)
                    n_erased++;
                if (want.purged != 0)
                    n_purges++;
            end
        end
    end

    task automatic test_basic_modes();
        send(rcpm_pkg::MODE_PURGE, '0, '0, '0);
        send(rcpm_pkg::MODE_LOOKUP, '0, '0, '0);
        send(rcpm_pkg::MODE_STORE, '0, '0, '0);
        send(rcpm_pkg::MODE_STORE, '1, '1, '1);
        send(rcpm_pkg::MODE_LOOKUP, '1, 16'h0000, 16'hffff);
        send(rcpm_pkg::MODE_REF, '1, '0, '0);
        send(rcpm_pkg::MODE_REPLACE, '0, 16'hffff, 16'h0000);
        send(rcpm_pkg::MODE_REPLACE, 64'h8000_0000_0000_0001, 16'h5a5a, 16'ha5a5);
        send(rcpm_pkg::MODE_LOOKUP, 64'h7fff_ffff_ffff_fffe, '1, '1);
        send(rcpm_pkg::MODE_LOOKUP, 64'h8000_0000_0000_0001, '0, '0);
    endtask

    task automatic test_store_conflicts();
        send(rcpm_pkg::MODE_STORE, '1, '1, '1);
        send(rcpm_pkg::MODE_STORE, '1, 16'h1234, 16'h5678);
        send(rcpm_pkg::MODE_STORE, '0, 16'hffff, 16'h0000);
    endtask

    task automatic test_refcount();
        send(rcpm_pkg::MODE_UNREF, '1, '0, '0);
        send(rcpm_pkg::MODE_UNREF, '1, '0, '0);
        send(rcpm_pkg::MODE_LOOKUP, '1, '0, '0);
        send(rcpm_pkg::MODE_UNREF, '1, '0, '0);
        send(rcpm_pkg::MODE_REF, 64'h8000_0000_0000_0001, '0, '0);
        send(rcpm_pkg::MODE_REPLACE, 64'h8000_0000_0000_0001, 16'h0001, 16'h8000);
        send(rcpm_pkg::MODE_UNREF, 64'h8000_0000_0000_0001, '0, '0);
    endtask

    task automatic test_spare_modes();
        send(MODE_SPARE_6, '1, '1, '1);
        send(MODE_SPARE_7, '0, '1, '1);
        send(rcpm_pkg::MODE_LOOKUP, '0, '0, '0);
    endtask

    task automatic test_purge();
        send(rcpm_pkg::MODE_PURGE, '1, '1, '1);
        send(rcpm_pkg::MODE_LOOKUP, '0, '0, '0);
    endtask

    task automatic test_full_table();
        logic [rcpm_pkg::KEY_W-1:0] base;
        base = {$urandom, $urandom} & ~rcpm_pkg::KEY_W'(rcpm_pkg::ENTRIES - 1);
        send(rcpm_pkg::MODE_PURGE, '0, '0, '0);
        for (int i = 0; i < rcpm_pkg::ENTRIES; i++)
            send(rcpm_pkg::MODE_STORE, base | rcpm_pkg::KEY_W'(i),
                 rcpm_pkg::HALF_W'($urandom), rcpm_pkg::HALF_W'($urandom));
        send(rcpm_pkg::MODE_STORE, ~base, 16'h1111, 16'h2222);
        send(rcpm_pkg::MODE_REPLACE, ~base, 16'h3333, 16'h4444);
        send(rcpm_pkg::MODE_REF, base | rcpm_pkg::KEY_W'(5), '0, '0);
        // free one slot in the middle, refill it, then hit the wall again
        send(rcpm_pkg::MODE_UNREF, base | rcpm_pkg::KEY_W'(10), '0, '0);
        send(rcpm_pkg::MODE_STORE, ~base, 16'h5555, 16'h6666);
        send(rcpm_pkg::MODE_REPLACE, base, 16'h7777, 16'h8888);
        send(rcpm_pkg::MODE_STORE, ~base ^ 64'h1, 16'h9999, 16'haaaa);
        send(rcpm_pkg::MODE_PURGE, '0, '0, '0);
    endtask

    task automatic test_random_traffic();
        int                          pick;
        int                          p;
        logic [rcpm_pkg::KEY_W-1:0]  k;
        logic [rcpm_pkg::FAR_W-1:0]  pr;
        logic [rcpm_pkg::MODE_W-1:0] m;
        key_pool[0] = '0;
        key_pool[1] = '1;
        for (int i = 2; i < POOL_KEYS; i++)
            key_pool[i] = {$urandom, $urandom};
        for (int i = 0; i < POOL_KEYS; i++)
            pair_pool[i] = $urandom;
        for (int n = 0; n < RANDOM_WORDS; n++)
        begin
            // run the tail with the sender at full rate
            if (n == RANDOM_WORDS - 80)
                gaps_on = 1'b0;
            p = $urandom_range(0, POOL_KEYS - 1);
            k = ($urandom_range(0, 9) == 0) ? {$urandom, $urandom} : key_pool[p];
            pr = ($urandom_range(0, 1) == 1) ? pair_pool[p] : rcpm_pkg::FAR_W'($urandom);
            pick = $urandom_range(0, 99);
            if (pick < 25)
                m = rcpm_pkg::MODE_STORE;
            else if (pick < 35)
                m = rcpm_pkg::MODE_REPLACE;
            else if (pick < 50)
                m = rcpm_pkg::MODE_LOOKUP;
            else if (pick < 70)
                m = rcpm_pkg::MODE_REF;
            else if (pick < 95)
                m = rcpm_pkg::MODE_UNREF;
            else if (pick < 97)
                m = rcpm_pkg::MODE_PURGE;
            else if (pick < 98)
                m = MODE_SPARE_6;
            else
                m = MODE_SPARE_7;
            send(m, k, pr[rcpm_pkg::FAR_W-1:rcpm_pkg::HALF_W], pr[rcpm_pkg::HALF_W-1:0]);
        end
    endtask

    initial
    begin
        for (int i = 0; i < rcpm_pkg::ENTRIES; i++)
        begin
            tab_valid[i] = 1'b0;
            tab_key[i] = '0;
            tab_far[i] = '0;
            tab_refs[i] = '0;
        end
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_basic_modes();
        test_store_conflicts();
        test_refcount();
        test_spare_modes();
        test_purge();
        test_full_table();
        test_random_traffic();

        start = 1'b0;
        while (pending_replies.size() != 0)
            @(negedge clk);
        repeat (rcpm_pkg::ENTRIES + 8) @(negedge clk);

        $display("%0d commands: %0d ok, %0d misses, %0d store conflicts, %0d table full",
                 n_words, n_hits, n_misses, n_conflicts, n_full);
        $display("%0d entries erased by unref, %0d purges that cleared entries",
                 n_erased, n_purges);
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

FILE: filelist.f
hdl/rcpm_pkg.sv
hdl/rcpm_ctrl.sv
hdl/rcpm_dp.sv
hdl/refcounted_pointer_map.sv
hdl/rcpm_checker.sv
sim/tb.sv
